// ----- rtl/dmf_pkg.sv -----
// Shared constants, types and pointer helpers for the dual message queue.
package dmf_pkg;

  // Bytes per ring; pointers count modulo twice that
  localparam int QUEUE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(QUEUE_BYTES);
  localparam int PTR_W       = $clog2(2 * QUEUE_BYTES);
  localparam int ENTRY_W     = 10;
  localparam int NUM_QUEUES  = 2;

  // Word commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Stored entry: overflow flag, end mark, byte
  typedef struct packed {
    logic       ovf;
    logic       last;
    logic [7:0] data;
  } entry_t;

  // Advance a pointer, wrapping at twice the ring size
  function automatic ptr_t ptr_next(input ptr_t p);
    logic [PTR_W:0] n;
    n = {1'b0, p} + (PTR_W+1)'(1);
    if (n >= (PTR_W+1)'(2 * QUEUE_BYTES)) begin
      ptr_next = '0;
    end else begin
      ptr_next = n[PTR_W-1:0];
    end
  endfunction

  // Ring slot addressed by a pointer
  function automatic addr_t ptr_slot(input ptr_t p);
    ptr_t s;
    if (p >= PTR_W'(QUEUE_BYTES)) begin
      s = p - PTR_W'(QUEUE_BYTES);
    end else begin
      s = p;
    end
    ptr_slot = s[ADDR_W-1:0];
  endfunction

  // Entries held between read and write pointers
  function automatic logic [PTR_W:0] ring_fill(input ptr_t wr, input ptr_t rd);
    if (wr >= rd) begin
      ring_fill = {1'b0, wr} - {1'b0, rd};
    end else begin
      ring_fill = {1'b0, wr} + (PTR_W+1)'(2 * QUEUE_BYTES) - {1'b0, rd};
    end
  endfunction

endpackage

// ----- rtl/dmf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dmf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dual_message_fifo.sv -----
// Top level: two message rings (send, receive) with commit-on-last-byte.
// A result word passes through the in-flight stage and then the output register.
// Throughput: one word per cycle while out_stall is low; the registered RAM read
// feeds a single in-flight stage and the output register, both cleared of stalls in step.
// Reset: synchronous rst_n clears pointers, drop flags and valid bits at once;
// ring contents are not cleared and need no clearing pass.
module dual_message_fifo
  import dmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic       in_queue_sel,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       in_overflow_flag,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_overflow,
  output logic [1:0] out_status
);

  // Per-queue pointers and drop state
  ptr_t rd_ptr_r   [NUM_QUEUES];
  ptr_t wr_ptr_r   [NUM_QUEUES];
  ptr_t cm_ptr_r   [NUM_QUEUES];
  logic drop_r     [NUM_QUEUES];
  ptr_t rd_ptr_nxt [NUM_QUEUES];
  ptr_t wr_ptr_nxt [NUM_QUEUES];
  ptr_t cm_ptr_nxt [NUM_QUEUES];
  logic drop_nxt   [NUM_QUEUES];

  // In-flight stage (waiting on RAM read data)
  logic    s1_valid_r;
  logic    s1_rd_ok_r;
  logic    s1_sel_r;
  status_t s1_status_r;
  status_t status_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_ovf_r;
  status_t    out_status_r;

  logic      in_take;
  logic      out_free;
  logic      rd_ok;
  logic      wr_en;
  logic      q;
  logic [PTR_W:0] fill;
  entry_t    wr_entry;
  addr_t     wr_addr;
  addr_t     rd_addr;
  logic [ENTRY_W-1:0] rdata [NUM_QUEUES];
  entry_t    rd_entry;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign q        = in_queue_sel;
  assign fill     = ring_fill(wr_ptr_r[q], rd_ptr_r[q]);

  // Command decode and pointer update for the selected queue
  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      rd_ptr_nxt[i] = rd_ptr_r[i];
      wr_ptr_nxt[i] = wr_ptr_r[i];
      cm_ptr_nxt[i] = cm_ptr_r[i];
      drop_nxt[i]   = drop_r[i];
    end
    status_nxt = ST_OK;
    rd_ok      = 1'b0;
    wr_en      = 1'b0;
    wr_entry   = '{ovf: in_overflow_flag, last: in_last_byte, data: in_data_byte};
    wr_addr    = ptr_slot(wr_ptr_r[q]);
    rd_addr    = ptr_slot(rd_ptr_r[q]);
    if (in_take) begin
      case (in_cmd)
        CMD_PUSH: begin
          if (drop_r[q]) begin
            status_nxt = ST_DROPPED;
            if (in_last_byte) begin
              drop_nxt[q] = 1'b0;
            end
          end else if (fill >= (PTR_W+1)'(QUEUE_BYTES)) begin
            // Ring full: discard the partial message
            wr_ptr_nxt[q] = cm_ptr_r[q];
            status_nxt    = ST_DROPPED;
            if (!in_last_byte) begin
              drop_nxt[q] = 1'b1;
            end
          end else begin
            wr_en         = 1'b1;
            wr_ptr_nxt[q] = ptr_next(wr_ptr_r[q]);
            if (in_last_byte) begin
              cm_ptr_nxt[q] = ptr_next(wr_ptr_r[q]);
            end
          end
        end
        CMD_POP: begin
          if (rd_ptr_r[q] == cm_ptr_r[q]) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_ok         = 1'b1;
            rd_ptr_nxt[q] = ptr_next(rd_ptr_r[q]);
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  // Pointer and drop registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        cm_ptr_r[i] <= '0;
        drop_r[i]   <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_r[i] <= rd_ptr_nxt[i];
        wr_ptr_r[i] <= wr_ptr_nxt[i];
        cm_ptr_r[i] <= cm_ptr_nxt[i];
        drop_r[i]   <= drop_nxt[i];
      end
    end
  end

  // Ring storage: index 0 send, index 1 receive
  dmf_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_BYTES)) u_send_ram (
    .clk     (clk),
    .we      (wr_en && !q),
    .waddr   (wr_addr),
    .wdata   (wr_entry),
    .re      (rd_ok && !q),
    .raddr   (rd_addr),
    .rdata_r (rdata[0])
  );

  dmf_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_BYTES)) u_recv_ram (
    .clk     (clk),
    .we      (wr_en && q),
    .waddr   (wr_addr),
    .wdata   (wr_entry),
    .re      (rd_ok && q),
    .raddr   (rd_addr),
    .rdata_r (rdata[1])
  );

  // In-flight stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_rd_ok_r  <= rd_ok;
      s1_sel_r    <= q;
      s1_status_r <= status_nxt;
    end
  end

  // Output register, loaded from the in-flight stage
  assign rd_entry = entry_t'(rdata[s1_sel_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_status_r <= s1_status_r;
      if (s1_rd_ok_r) begin
        out_byte_r <= rd_entry.data;
        out_last_r <= rd_entry.last;
        out_ovf_r  <= rd_entry.ovf;
      end else begin
        out_byte_r <= '0;
        out_last_r <= 1'b0;
        out_ovf_r  <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;
  assign out_status   = out_status_r;

endmodule
